[sv/vbde_pkg.sv]
// shared types and constants of the vram block dma engine
package vbde_pkg;

  localparam int unsigned BLOCK_BYTES = 16;
  localparam int unsigned BL_W        = 5;
  localparam logic [BL_W-1:0] BLOCK_LEN = BL_W'(BLOCK_BYTES);

  localparam logic OP_TICK      = 1'b0;
  localparam logic OP_REG_WRITE = 1'b1;

  localparam logic [2:0] REG_SRC_HI  = 3'd0;
  localparam logic [2:0] REG_SRC_LO  = 3'd1;
  localparam logic [2:0] REG_DST_HI  = 3'd2;
  localparam logic [2:0] REG_DST_LO  = 3'd3;
  localparam logic [2:0] REG_CONTROL = 3'd4;

  localparam logic [7:0] ADDR_LO_MASK  = 8'hF0;
  localparam logic [7:0] DST_HI_MASK   = 8'h1F;
  localparam logic [7:0] DST_HI_SET    = 8'h80;
  localparam logic [7:0] CTRL_CNT_MASK = 8'h7F;
  localparam int unsigned CTRL_HBLANK_BIT = 7;

  typedef enum logic [3:0] {
    MODE_IDLE    = 4'b0001,
    MODE_GENERAL = 4'b0010,
    MODE_HBLANK  = 4'b0100,
    MODE_WAIT    = 4'b1000
  } mode_t;

  typedef struct packed {
    logic       opcode;
    logic [2:0] reg_select;
    logic [7:0] write_data;
    logic [1:0] lcd_mode;
    logic       double_speed;
  } item_t;

  typedef struct packed {
    logic        copy_valid;
    logic [15:0] copy_source;
    logic [15:0] copy_dest;
    logic        cpu_halted;
    logic [7:0]  control_value;
    logic        engine_active;
    logic        last;
  } result_t;

endpackage

[sv/vbde_in_if.sv]
// input channel: register writes and ticks
interface vbde_in_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [2:0] reg_select;
  logic [7:0] write_data;
  logic [1:0] lcd_mode;
  logic       double_speed;

  modport source (output valid, opcode, reg_select, write_data, lcd_mode, double_speed,
                  input ready);
  modport sink (input valid, opcode, reg_select, write_data, lcd_mode, double_speed,
                output ready);
endinterface

[sv/vbde_out_if.sv]
// result channel: byte copy commands and status
interface vbde_out_if;
  logic        valid;
  logic        ready;
  logic        copy_valid;
  logic [15:0] copy_source;
  logic [15:0] copy_dest;
  logic        cpu_halted;
  logic [7:0]  control_value;
  logic        engine_active;
  logic        last;

  modport source (output valid, copy_valid, copy_source, copy_dest, cpu_halted,
                  control_value, engine_active, last, input ready);
  modport sink (input valid, copy_valid, copy_source, copy_dest, cpu_halted,
                control_value, engine_active, last, output ready);
endinterface

[sv/vbde_core.sv]
// dma engine state and per-item next-state and result logic
module vbde_core (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept_i,
  input  vbde_pkg::item_t  item_i,
  output vbde_pkg::result_t res0_o,
  output vbde_pkg::result_t res1_o,
  output logic             two_o
);

  vbde_pkg::mode_t              mode_r, mode_nxt;
  logic [vbde_pkg::BL_W-1:0]    bytes_left_r, bytes_left_nxt;
  logic [1:0]                   prior_lcd_r, prior_lcd_nxt;
  logic [15:0]                  src_r, src_nxt;
  logic [15:0]                  dst_r, dst_nxt;
  logic [7:0]                   addr_r [4];
  logic [7:0]                   addr_nxt [4];
  logic [7:0]                   ctrl_r, ctrl_nxt;
  logic                         pend_r, pend_nxt;
  logic                         halt_r, halt_nxt;

  logic [15:0]                  src_base, dst_base, src_after, dst_after;
  logic [vbde_pkg::BL_W-1:0]    bl1, bl2;
  logic                         second;
  logic                         do_copy, is_general;
  logic [7:0]                   a1_masked, a3_masked, dhi;

  assign bl1    = (bytes_left_r != '0) ? bytes_left_r - 1'b1 : '0;
  assign second = !item_i.double_speed && (bl1 != '0);
  assign bl2    = second ? bl1 - 1'b1 : bl1;

  assign a1_masked = addr_r[1] & vbde_pkg::ADDR_LO_MASK;
  assign a3_masked = addr_r[3] & vbde_pkg::ADDR_LO_MASK;
  assign dhi       = (addr_r[2] & vbde_pkg::DST_HI_MASK) | vbde_pkg::DST_HI_SET;

  // a start from idle reads the address registers, otherwise the running pointers
  assign src_base = (mode_r == vbde_pkg::MODE_IDLE) ? {addr_r[0], a1_masked} : src_r;
  assign dst_base = (mode_r == vbde_pkg::MODE_IDLE) ? {dhi, a3_masked} : dst_r;

  assign src_after = src_base + 16'd1 + {15'd0, second};
  assign dst_after = dst_base + 16'd1 + {15'd0, second};

  always_comb begin
    mode_nxt       = mode_r;
    bytes_left_nxt = bytes_left_r;
    prior_lcd_nxt  = prior_lcd_r;
    src_nxt        = src_r;
    dst_nxt        = dst_r;
    addr_nxt       = addr_r;
    ctrl_nxt       = ctrl_r;
    pend_nxt       = pend_r;
    halt_nxt       = halt_r;
    do_copy        = 1'b0;
    is_general     = 1'b0;

    if (accept_i) begin
      if (item_i.opcode == vbde_pkg::OP_REG_WRITE) begin
        if (!item_i.reg_select[2]) begin
          addr_nxt[item_i.reg_select[1:0]] = item_i.write_data;
        end else if (item_i.reg_select == vbde_pkg::REG_CONTROL) begin
          ctrl_nxt = item_i.write_data;
          pend_nxt = 1'b1;
        end
      end else begin
        case (mode_r)
          vbde_pkg::MODE_IDLE: begin
            if (pend_r) begin
              pend_nxt = 1'b0;
              src_nxt  = src_base;
              dst_nxt  = dst_base;
              if (ctrl_r[vbde_pkg::CTRL_HBLANK_BIT]) begin
                prior_lcd_nxt = item_i.lcd_mode;
                mode_nxt      = vbde_pkg::MODE_WAIT;
              end else begin
                mode_nxt   = vbde_pkg::MODE_GENERAL;
                halt_nxt   = 1'b1;
                do_copy    = 1'b1;
                is_general = 1'b1;
              end
            end
          end
          vbde_pkg::MODE_GENERAL: begin
            do_copy    = 1'b1;
            is_general = 1'b1;
          end
          vbde_pkg::MODE_HBLANK: begin
            do_copy = 1'b1;
          end
          vbde_pkg::MODE_WAIT: begin
            // a control write cancels, even on the tick that enters hblank
            if (pend_r) begin
              pend_nxt = 1'b0;
              ctrl_nxt = ctrl_r & vbde_pkg::CTRL_CNT_MASK;
              mode_nxt = vbde_pkg::MODE_IDLE;
              halt_nxt = 1'b0;
            end else if (item_i.lcd_mode == 2'd0 && prior_lcd_r != 2'd0) begin
              mode_nxt = vbde_pkg::MODE_HBLANK;
              halt_nxt = 1'b1;
            end
            prior_lcd_nxt = item_i.lcd_mode;
          end
          default: begin
            mode_nxt = vbde_pkg::MODE_IDLE;
          end
        endcase

        if (do_copy) begin
          src_nxt = src_after;
          dst_nxt = dst_after;
          if (bl2 == '0) begin
            // end of block: write pointers back to the address registers
            bytes_left_nxt = vbde_pkg::BLOCK_LEN;
            addr_nxt[0] = src_after[15:8];
            addr_nxt[1] = src_after[7:0];
            addr_nxt[2] = dst_after[15:8];
            addr_nxt[3] = dst_after[7:0];
            if (is_general) begin
              if (ctrl_r == 8'd0) begin
                mode_nxt = vbde_pkg::MODE_IDLE;
                halt_nxt = 1'b0;
              end else begin
                ctrl_nxt = ctrl_r - 8'd1;
              end
            end else begin
              if ((ctrl_r & vbde_pkg::CTRL_CNT_MASK) == 8'd0) begin
                ctrl_nxt = 8'd0;
                mode_nxt = vbde_pkg::MODE_IDLE;
              end else begin
                ctrl_nxt      = ctrl_r - 8'd1;
                prior_lcd_nxt = item_i.lcd_mode;
                mode_nxt      = vbde_pkg::MODE_WAIT;
              end
              halt_nxt = 1'b0;
            end
          end else begin
            bytes_left_nxt = bl2;
          end
        end
      end
    end
  end

  assign two_o = do_copy && second;

  always_comb begin
    res0_o.copy_valid    = do_copy;
    res0_o.copy_source   = do_copy ? src_base : 16'd0;
    res0_o.copy_dest     = do_copy ? dst_base : 16'd0;
    res0_o.cpu_halted    = halt_nxt;
    res0_o.control_value = ctrl_nxt;
    res0_o.engine_active = (mode_nxt != vbde_pkg::MODE_IDLE);
    res0_o.last          = !two_o;

    res1_o.copy_valid    = 1'b1;
    res1_o.copy_source   = src_base + 16'd1;
    res1_o.copy_dest     = dst_base + 16'd1;
    res1_o.cpu_halted    = halt_nxt;
    res1_o.control_value = ctrl_nxt;
    res1_o.engine_active = (mode_nxt != vbde_pkg::MODE_IDLE);
    res1_o.last          = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= vbde_pkg::MODE_IDLE;
      bytes_left_r <= vbde_pkg::BLOCK_LEN;
      prior_lcd_r  <= 2'd0;
      src_r        <= 16'd0;
      dst_r        <= 16'd0;
      addr_r       <= '{default: 8'd0};
      ctrl_r       <= 8'd0;
      pend_r       <= 1'b0;
      halt_r       <= 1'b0;
    end else begin
      mode_r       <= mode_nxt;
      bytes_left_r <= bytes_left_nxt;
      prior_lcd_r  <= prior_lcd_nxt;
      src_r        <= src_nxt;
      dst_r        <= dst_nxt;
      addr_r       <= addr_nxt;
      ctrl_r       <= ctrl_nxt;
      pend_r       <= pend_nxt;
      halt_r       <= halt_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_halt_only_copying: assert property (@(posedge clk) disable iff (!rst_n)
    halt_r |-> (mode_r == vbde_pkg::MODE_GENERAL || mode_r == vbde_pkg::MODE_HBLANK))
    else $error("cpu halted outside a block copy");

  a_full_block_when_parked: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == vbde_pkg::MODE_IDLE || mode_r == vbde_pkg::MODE_WAIT)
      |-> bytes_left_r == vbde_pkg::BLOCK_LEN)
    else $error("byte count not reloaded outside a block");

  a_bytes_left_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    bytes_left_r != '0)
    else $error("byte count reached zero without reload");
`endif

endmodule

[sv/vram_block_dma_engine.sv]
// top level of the vram block dma engine with its two-entry result buffer
//
// channel  dir  transfer carries
// in_ch    in   opcode, reg_select, write_data, lcd_mode, double_speed
// out_ch   out  copy_valid, copy_source, copy_dest, cpu_halted, control_value,
//               engine_active, last
//
// an item is decoded against the engine state in the cycle it is taken and its
// one or two results land in the result buffer on the next edge
// a tick that copies two bytes holds the input until its second result leaves, so
// input takes one item per cycle when results are single and out_ch is ready
// in_ch.ready is high when the buffer is empty or its last result leaves now
// reset is synchronous and active low and restores the idle engine
module vram_block_dma_engine (
  input  logic           clk,
  input  logic           rst_n,
  vbde_in_if.sink        in_ch,
  vbde_out_if.source     out_ch
);

  vbde_pkg::item_t   item;
  vbde_pkg::result_t res0, res1;
  vbde_pkg::result_t slot0_r, slot0_nxt;
  vbde_pkg::result_t slot1_r, slot1_nxt;
  logic [1:0]        count_r, count_nxt;
  logic              two;
  logic              accept, pop;

  assign item.opcode       = in_ch.opcode;
  assign item.reg_select   = in_ch.reg_select;
  assign item.write_data   = in_ch.write_data;
  assign item.lcd_mode     = in_ch.lcd_mode;
  assign item.double_speed = in_ch.double_speed;

  assign in_ch.ready = (count_r == 2'd0) || (count_r == 2'd1 && out_ch.ready);
  assign accept      = in_ch.valid && in_ch.ready;
  assign pop         = out_ch.valid && out_ch.ready;

  vbde_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept_i (accept),
    .item_i   (item),
    .res0_o   (res0),
    .res1_o   (res1),
    .two_o    (two)
  );

  always_comb begin
    count_nxt = count_r;
    slot0_nxt = slot0_r;
    slot1_nxt = slot1_r;
    if (accept) begin
      count_nxt = two ? 2'd2 : 2'd1;
      slot0_nxt = res0;
      slot1_nxt = res1;
    end else if (pop) begin
      count_nxt = count_r - 2'd1;
      slot0_nxt = slot1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 2'd0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot0_r <= slot0_nxt;
    slot1_r <= slot1_nxt;
  end

  assign out_ch.valid         = (count_r != 2'd0);
  assign out_ch.copy_valid    = slot0_r.copy_valid;
  assign out_ch.copy_source   = slot0_r.copy_source;
  assign out_ch.copy_dest     = slot0_r.copy_dest;
  assign out_ch.cpu_halted    = slot0_r.cpu_halted;
  assign out_ch.control_value = slot0_r.control_value;
  assign out_ch.engine_active = slot0_r.engine_active;
  assign out_ch.last          = slot0_r.last;

`ifndef ASSERT_OFF
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != 2'd3)
    else $error("result buffer count out of range");

  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_ch.valid)
    else $error("accepted item left no result");

  a_two_ends_last: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == 2'd2) |-> (!slot0_r.last && slot1_r.last && slot1_r.copy_valid))
    else $error("paired copy results out of order");
`endif

endmodule

[verif/tb_vram_block_dma_engine.sv]
// testbench for the vram block dma engine: random and directed items checked against a predictor
`timescale 1ns / 1ps

module tb_vram_block_dma_engine;

  localparam logic [2:0] REG_UNUSED_LO = 3'd5;
  localparam logic [2:0] REG_UNUSED_HI = 3'd7;
  localparam int unsigned ITEM_TARGET   = 1500;
  localparam int unsigned STALL_LIMIT   = 3000;
  localparam int unsigned HOLDOFF_LEN   = 300;
  localparam int unsigned HOLDOFF_AT    = 400;
  localparam int unsigned CALM_FROM     = 800;
  localparam int unsigned CALM_TO       = 1100;
  localparam int unsigned IDLE_PERCENT  = 29;
  localparam int unsigned DRAIN_CYCLES  = 20;

  logic clk;
  logic rst_n;

  vbde_in_if  in_ch();
  vbde_out_if out_ch();

  vram_block_dma_engine uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #5 clk = ~clk;

  // predicted engine state
  vbde_pkg::mode_t           eng_mode;
  logic [vbde_pkg::BL_W-1:0] bytes_left;
  logic [1:0]                prior_lcd;
  logic [15:0]               src_ptr;
  logic [15:0]               dst_ptr;
  logic [7:0]                addr_regs [4];
  logic [7:0]                ctrl_reg;
  logic                      ctrl_pending;
  logic                      halted;

  logic [15:0] copy_src [2];
  logic [15:0] copy_dst [2];
  int          tick_copies;

  vbde_pkg::item_t   items_to_send [$];
  vbde_pkg::result_t engine_outputs [$];

  int mismatches;
  int items_accepted;
  int ticks_accepted;
  int results_checked;
  int copies_checked;
  int stall_cycles;
  int holdoff_left;
  bit holdoff_done;
  bit in_taken;

  function automatic bit calm();
    return items_accepted >= CALM_FROM && items_accepted < CALM_TO;
  endfunction

  task automatic record_copy();
    copy_src[tick_copies] = src_ptr;
    copy_dst[tick_copies] = dst_ptr;
    tick_copies++;
    src_ptr++;
    dst_ptr++;
    if (bytes_left != 0) bytes_left--;
  endtask

  task automatic copy_bytes(input logic dbl);
    record_copy();
    if (!dbl && bytes_left != 0) record_copy();
  endtask

  task automatic store_pointers();
    bytes_left   = vbde_pkg::BLOCK_LEN;
    addr_regs[0] = src_ptr[15:8];
    addr_regs[1] = src_ptr[7:0];
    addr_regs[2] = dst_ptr[15:8];
    addr_regs[3] = dst_ptr[7:0];
  endtask

  task automatic general_step(input logic dbl);
    copy_bytes(dbl);
    if (bytes_left == 0) begin
      store_pointers();
      if (ctrl_reg == 0) begin
        eng_mode = vbde_pkg::MODE_IDLE;
        halted   = 1'b0;
      end else begin
        ctrl_reg--;
      end
    end
  endtask

  // applies one accepted item to the predicted state and queues its results
  task automatic advance_engine(input vbde_pkg::item_t it);
    vbde_pkg::result_t res;
    int                n;
    tick_copies = 0;
    if (it.opcode == vbde_pkg::OP_REG_WRITE) begin
      if (it.reg_select <= vbde_pkg::REG_DST_LO) begin
        addr_regs[it.reg_select[1:0]] = it.write_data;
      end else if (it.reg_select == vbde_pkg::REG_CONTROL) begin
        ctrl_reg     = it.write_data;
        ctrl_pending = 1'b1;
      end
    end else begin
      ticks_accepted++;
      case (eng_mode)
        vbde_pkg::MODE_IDLE: begin
          if (ctrl_pending) begin
            ctrl_pending = 1'b0;
            src_ptr = {addr_regs[0], addr_regs[1] & vbde_pkg::ADDR_LO_MASK};
            dst_ptr = {(addr_regs[2] & vbde_pkg::DST_HI_MASK) | vbde_pkg::DST_HI_SET,
                       addr_regs[3] & vbde_pkg::ADDR_LO_MASK};
            if (ctrl_reg[vbde_pkg::CTRL_HBLANK_BIT]) begin
              prior_lcd = it.lcd_mode;
              eng_mode  = vbde_pkg::MODE_WAIT;
            end else begin
              eng_mode = vbde_pkg::MODE_GENERAL;
              halted   = 1'b1;
              general_step(it.double_speed);
            end
          end
        end
        vbde_pkg::MODE_GENERAL: general_step(it.double_speed);
        vbde_pkg::MODE_HBLANK: begin
          copy_bytes(it.double_speed);
          if (bytes_left == 0) begin
            store_pointers();
            if ((ctrl_reg & vbde_pkg::CTRL_CNT_MASK) == 0) begin
              ctrl_reg = 8'h00;
              eng_mode = vbde_pkg::MODE_IDLE;
            end else begin
              ctrl_reg--;
              prior_lcd = it.lcd_mode;
              eng_mode  = vbde_pkg::MODE_WAIT;
            end
            halted = 1'b0;
          end
        end
        vbde_pkg::MODE_WAIT: begin
          // a control write cancels even when hblank starts on this tick
          if (ctrl_pending) begin
            ctrl_pending = 1'b0;
            ctrl_reg     = ctrl_reg & vbde_pkg::CTRL_CNT_MASK;
            eng_mode     = vbde_pkg::MODE_IDLE;
            halted       = 1'b0;
          end else if (it.lcd_mode == 0 && prior_lcd != 0) begin
            eng_mode = vbde_pkg::MODE_HBLANK;
            halted   = 1'b1;
          end
          prior_lcd = it.lcd_mode;
        end
        default: ;
      endcase
    end
    n = (tick_copies == 0) ? 1 : tick_copies;
    for (int k = 0; k < n; k++) begin
      res.copy_valid    = (tick_copies != 0);
      res.copy_source   = (tick_copies != 0) ? copy_src[k] : 16'h0000;
      res.copy_dest     = (tick_copies != 0) ? copy_dst[k] : 16'h0000;
      res.cpu_halted    = halted;
      res.control_value = ctrl_reg;
      res.engine_active = (eng_mode != vbde_pkg::MODE_IDLE);
      res.last          = (k == n - 1);
      engine_outputs.push_back(res);
    end
  endtask

  task automatic add_write(input logic [2:0] sel, input logic [7:0] data);
    vbde_pkg::item_t it;
    it.opcode       = vbde_pkg::OP_REG_WRITE;
    it.reg_select   = sel;
    it.write_data   = data;
    it.lcd_mode     = 2'($urandom);
    it.double_speed = 1'($urandom);
    items_to_send.push_back(it);
  endtask

  task automatic add_tick(input logic [1:0] lcd, input logic dbl);
    vbde_pkg::item_t it;
    it.opcode       = vbde_pkg::OP_TICK;
    it.reg_select   = 3'($urandom);
    it.write_data   = 8'($urandom);
    it.lcd_mode     = lcd;
    it.double_speed = dbl;
    items_to_send.push_back(it);
  endtask

  task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  // sender: a new item goes out once the previous one is transferred
  always @(negedge clk) begin
    vbde_pkg::item_t it;
    if (rst_n && (!in_ch.valid || in_taken)) begin
      if (items_to_send.size() != 0 && (calm() || $urandom_range(0, 99) >= IDLE_PERCENT)) begin
        it = items_to_send.pop_front();
        in_ch.valid        <= 1'b1;
        in_ch.opcode       <= it.opcode;
        in_ch.reg_select   <= it.reg_select;
        in_ch.write_data   <= it.write_data;
        in_ch.lcd_mode     <= it.lcd_mode;
        in_ch.double_speed <= it.double_speed;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // receiver: random stalls plus one long hold-off to back the block up
  always @(negedge clk) begin
    if (rst_n) begin
      if (holdoff_left != 0) begin
        holdoff_left--;
        out_ch.ready <= 1'b0;
      end else if (!holdoff_done && items_accepted >= HOLDOFF_AT) begin
        holdoff_done = 1'b1;
        holdoff_left = HOLDOFF_LEN;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= calm() || ($urandom_range(0, 99) >= IDLE_PERCENT);
      end
    end
  end

  // monitor: predicts on each input transfer, checks each result transfer
  always @(posedge clk) begin
    vbde_pkg::result_t want;
    vbde_pkg::item_t   it;
    in_taken = rst_n && in_ch.valid && in_ch.ready;
    if (in_taken) begin
      it.opcode       = in_ch.opcode;
      it.reg_select   = in_ch.reg_select;
      it.write_data   = in_ch.write_data;
      it.lcd_mode     = in_ch.lcd_mode;
      it.double_speed = in_ch.double_speed;
      items_accepted++;
      advance_engine(it);
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (engine_outputs.size() == 0) begin
        $error("result with no prediction waiting");
        mismatches++;
      end else begin
        want = engine_outputs.pop_front();
        results_checked++;
        if (want.copy_valid) copies_checked++;
        check_field("copy_valid", 16'(want.copy_valid), 16'(out_ch.copy_valid));
        check_field("copy_source", want.copy_source, out_ch.copy_source);
        check_field("copy_dest", want.copy_dest, out_ch.copy_dest);
        check_field("cpu_halted", 16'(want.cpu_halted), 16'(out_ch.cpu_halted));
        check_field("control_value", 16'(want.control_value), 16'(out_ch.control_value));
        check_field("engine_active", 16'(want.engine_active), 16'(out_ch.engine_active));
        check_field("last", 16'(want.last), 16'(out_ch.last));
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) stall_cycles = 0;
    else stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    int unsigned cnt;
    int unsigned n_ticks;
    logic        hb;
    clk                = 1'b0;
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.opcode       = vbde_pkg::OP_TICK;
    in_ch.reg_select   = vbde_pkg::REG_SRC_HI;
    in_ch.write_data   = 8'h00;
    in_ch.lcd_mode     = 2'd0;
    in_ch.double_speed = 1'b0;
    out_ch.ready       = 1'b0;
    eng_mode     = vbde_pkg::MODE_IDLE;
    bytes_left   = vbde_pkg::BLOCK_LEN;
    prior_lcd    = 2'd0;
    src_ptr      = 16'h0000;
    dst_ptr      = 16'h0000;
    for (int i = 0; i < 4; i++) addr_regs[i] = 8'h00;
    ctrl_reg     = 8'h00;
    ctrl_pending = 1'b0;
    halted       = 1'b0;

    // cancel while waiting, arriving on the same tick as the hblank entry
    add_write(vbde_pkg::REG_CONTROL, 8'h80);
    add_tick(2'd2, 1'b0);
    add_write(vbde_pkg::REG_CONTROL, 8'h05);
    add_tick(2'd0, 1'b0);
    add_tick(2'd1, 1'b1);
    add_write(REG_UNUSED_LO, 8'hAA);
    add_write(REG_UNUSED_HI, 8'h55);
    // top addresses: source wraps past ffff, destination masked into vram
    add_write(vbde_pkg::REG_SRC_HI, 8'hFF);
    add_write(vbde_pkg::REG_SRC_LO, 8'hFF);
    add_write(vbde_pkg::REG_DST_HI, 8'hFF);
    add_write(vbde_pkg::REG_DST_LO, 8'hFF);
    add_write(vbde_pkg::REG_CONTROL, 8'h00);
    add_tick(2'd3, 1'b0);
    add_tick(2'd0, 1'b1);
    // control writes during a copy take effect at once and restart later
    add_write(vbde_pkg::REG_CONTROL, 8'hFF);
    add_tick(2'd1, 1'b0);
    add_write(vbde_pkg::REG_CONTROL, 8'h00);
    repeat (6) add_tick(2'($urandom), 1'b0);

    while (items_to_send.size() < ITEM_TARGET) begin
      if ($urandom_range(0, 99) < 80) begin
        if ($urandom_range(0, 3) != 0) add_write(vbde_pkg::REG_SRC_HI, 8'($urandom));
        if ($urandom_range(0, 3) != 0) add_write(vbde_pkg::REG_SRC_LO, 8'($urandom));
        if ($urandom_range(0, 3) != 0) add_write(vbde_pkg::REG_DST_HI, 8'($urandom));
        if ($urandom_range(0, 3) != 0) add_write(vbde_pkg::REG_DST_LO, 8'($urandom));
        cnt = ($urandom_range(0, 19) == 0) ? $urandom_range(4, 12) : $urandom_range(0, 3);
        hb  = 1'($urandom);
        add_write(vbde_pkg::REG_CONTROL, {hb, 7'(cnt)});
        n_ticks = (cnt + 1) * (hb ? 22 : 12) + $urandom_range(0, 6);
        for (int unsigned t = 0; t < n_ticks; t++) begin
          if ($urandom_range(0, 99) < 2)
            add_write(vbde_pkg::REG_CONTROL, {1'($urandom), 5'd0, 2'($urandom)});
          add_tick(2'($urandom), 1'($urandom));
        end
      end else begin
        repeat ($urandom_range(1, 6)) begin
          if ($urandom_range(0, 1) == 0) begin
            add_tick(2'($urandom), 1'($urandom));
          end else begin
            cnt = $urandom_range(0, 7);
            if (3'(cnt) == vbde_pkg::REG_CONTROL)
              add_write(vbde_pkg::REG_CONTROL, {1'($urandom), 5'd0, 2'($urandom)});
            else
              add_write(3'(cnt), 8'($urandom));
          end
        end
      end
    end

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (items_to_send.size() != 0 || in_ch.valid) @(posedge clk);
    while (engine_outputs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d items sent (%0d ticks), %0d results checked, %0d of them byte copies",
             items_accepted, ticks_accepted, results_checked, copies_checked);
    $display("general, hblank, cancel and mid-copy control writes with random stalls");
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[vram_block_dma_engine.f]
sv/vbde_pkg.sv
sv/vbde_in_if.sv
sv/vbde_out_if.sv
sv/vbde_core.sv
sv/vram_block_dma_engine.sv
verif/tb_vram_block_dma_engine.sv
